// ===== rtl/lspq_pkg.sv =====
package lspq_pkg;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic ACTION_INSERT = 1'b0;
  localparam logic ACTION_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_SHIFT_START,
    ST_SHIFT,
    ST_FINISH
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_INSERT,
    CMD_REFUSE_FULL,
    CMD_REFUSE_EMPTY,
    CMD_SCAN_START,
    CMD_SCAN,
    CMD_SHIFT_START,
    CMD_SHIFT,
    CMD_FINISH_REMOVE
  } cmd_e;

  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic rd_last;
    logic shift_none;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/lspq_ctrl.sv =====
module lspq_ctrl
  import lspq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  dp_status_t status_i,
  output logic       in_ready_o,
  output cmd_e       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_ACCEPT;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.is_remove && !status_i.empty) begin
          cmd_o   = CMD_SCAN_START;
          state_d = ST_SCAN;
        end else if (status_i.out_free) begin
          // Refusals and inserts finish here.
          if (status_i.is_remove) begin
            cmd_o = CMD_REFUSE_EMPTY;
          end else if (status_i.full) begin
            cmd_o = CMD_REFUSE_FULL;
          end else begin
            cmd_o = CMD_INSERT;
          end
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o = CMD_SCAN;
        if (status_i.rd_last) begin
          state_d = ST_SHIFT_START;
        end
      end
      ST_SHIFT_START: begin
        if (status_i.shift_none) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o   = CMD_SHIFT_START;
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd_o = CMD_SHIFT;
        if (status_i.rd_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o   = CMD_FINISH_REMOVE;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/lspq_dp.sv =====
module lspq_dp
  import lspq_pkg::*;
#(
  parameter int DEPTH         = 4,
  parameter int VALUE_BITS    = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cmd_e                             cmd_i,
  input  logic                             in_action_i,
  input  logic [VALUE_BITS-1:0]            in_value_i,
  input  logic [PRIORITY_BITS-1:0]         in_priority_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [1:0]                       out_status_o,
  output logic [VALUE_BITS-1:0]            out_value_o,
  output logic [PRIORITY_BITS-1:0]         out_priority_o,
  output logic [$clog2(DEPTH+1)-1:0]       out_count_o,
  output dp_status_t                       status_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = PRIORITY_BITS + VALUE_BITS;

  // Entries are stored as {priority, value}, so one unsigned compare ranks
  // priority first and value second.
  logic [EW-1:0] mem [DEPTH];

  logic                     action_q;
  logic [VALUE_BITS-1:0]    value_q;
  logic [PRIORITY_BITS-1:0] prio_q;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [IW-1:0]            rd_addr_q, rd_addr_d;
  logic [EW-1:0]            rd_data_q;
  logic [IW-1:0]            best_idx_q;
  logic [EW-1:0]            best_ent_q;
  logic                     out_valid_q;
  logic [1:0]               out_status_q;
  logic [EW-1:0]            out_ent_q;
  logic [CW-1:0]            out_count_q;

  logic          rd_en, wr_en, res_load;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [1:0]    res_status;
  logic [EW-1:0] res_ent;
  logic [CW-1:0] cnt_last;
  logic          rd_last;

  assign cnt_last = cnt_q - CW'(1);
  assign rd_last  = (CW'(rd_addr_q) == cnt_last);

  assign status_o.is_remove  = (action_q == ACTION_REMOVE);
  assign status_o.full       = (cnt_q == CW'(DEPTH));
  assign status_o.empty      = (cnt_q == '0);
  assign status_o.rd_last    = rd_last;
  assign status_o.shift_none = (CW'(best_idx_q) == cnt_last);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    rd_en      = 1'b0;
    rd_addr_d  = rd_addr_q;
    wr_en      = 1'b0;
    wr_addr    = rd_addr_q - IW'(1);
    wr_data    = rd_data_q;
    res_load   = 1'b0;
    res_status = STATUS_OK;
    res_ent    = '0;
    cnt_d      = cnt_q;
    case (cmd_i)
      CMD_INSERT: begin
        wr_en    = 1'b1;
        wr_addr  = cnt_q[IW-1:0];
        wr_data  = {prio_q, value_q};
        cnt_d    = cnt_q + CW'(1);
        res_load = 1'b1;
        res_ent  = {prio_q, value_q};
      end
      CMD_REFUSE_FULL: begin
        res_load   = 1'b1;
        res_status = STATUS_FULL;
      end
      CMD_REFUSE_EMPTY: begin
        res_load   = 1'b1;
        res_status = STATUS_EMPTY;
      end
      CMD_SCAN_START: begin
        rd_en     = 1'b1;
        rd_addr_d = '0;
      end
      CMD_SCAN: begin
        if (!rd_last) begin
          rd_en     = 1'b1;
          rd_addr_d = rd_addr_q + IW'(1);
        end
      end
      CMD_SHIFT_START: begin
        rd_en     = 1'b1;
        rd_addr_d = best_idx_q + IW'(1);
      end
      CMD_SHIFT: begin
        // Move the entry just read down by one slot.
        wr_en = 1'b1;
        if (!rd_last) begin
          rd_en     = 1'b1;
          rd_addr_d = rd_addr_q + IW'(1);
        end
      end
      CMD_FINISH_REMOVE: begin
        cnt_d    = cnt_last;
        res_load = 1'b1;
        res_ent  = best_ent_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr_d];
      rd_addr_q <= rd_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_ACCEPT) begin
      action_q <= in_action_i;
      value_q  <= in_value_i;
      prio_q   <= in_priority_i;
    end
    // The first entry read always becomes the candidate.
    if (cmd_i == CMD_SCAN && (rd_addr_q == '0 || rd_data_q > best_ent_q)) begin
      best_idx_q <= rd_addr_q;
      best_ent_q <= rd_data_q;
    end
    if (res_load) begin
      out_status_q <= res_status;
      out_ent_q    <= res_ent;
      out_count_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = out_status_q;
  assign out_value_o    = out_ent_q[VALUE_BITS-1:0];
  assign out_priority_o = out_ent_q[EW-1:VALUE_BITS];
  assign out_count_o    = out_count_q;

endmodule

// ===== rtl/linear_scan_priority_queue_unit.sv =====
// Channel   Direction  tdata (low bit up)                        tuser
// s_axis    in         item_value, item_priority                 action
// m_axis    out        out_value, out_priority, entry_count      status
//
// An insert or a refused request has its result registered from the check state. A remove
// over N entries scans all of them, then shifts each one above the served one down a slot
// through the single read port of the entry memory. The next request is taken in idle.
// Reset clears the entry count and the output valid flag; entries need none.
// A waiting result does not block the next request; a result is only held
// back while the previous one is still waiting.
module linear_scan_priority_queue_unit
  import lspq_pkg::*;
#(
  parameter int DEPTH         = 4,
  parameter int VALUE_BITS    = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // item_value, item_priority, zero padding
  input  logic [((VALUE_BITS+PRIORITY_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // action
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // out_value, out_priority, entry_count, zero padding
  output logic [((VALUE_BITS+PRIORITY_BITS+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata_o,
  // status
  output logic [1:0]            m_axis_tuser_o
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int OUT_W = ((VALUE_BITS + PRIORITY_BITS + CW + 7) / 8) * 8;

  cmd_e                     cmd;
  dp_status_t               dp_status;
  logic [VALUE_BITS-1:0]    out_value;
  logic [PRIORITY_BITS-1:0] out_priority;
  logic [CW-1:0]            out_count;

  lspq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .status_i   (dp_status),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  lspq_dp #(
    .DEPTH         (DEPTH),
    .VALUE_BITS    (VALUE_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_action_i    (s_axis_tuser_i),
    .in_value_i     (s_axis_tdata_i[VALUE_BITS-1:0]),
    .in_priority_i  (s_axis_tdata_i[VALUE_BITS+PRIORITY_BITS-1:VALUE_BITS]),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_status_o   (m_axis_tuser_o),
    .out_value_o    (out_value),
    .out_priority_o (out_priority),
    .out_count_o    (out_count),
    .status_o       (dp_status)
  );

  assign m_axis_tdata_o = OUT_W'({out_count, out_priority, out_value});

endmodule

// ===== tb/sv/linear_scan_priority_queue_unit_checker.sv =====
`timescale 1ns / 100ps

module linear_scan_priority_queue_unit_checker
  import lspq_pkg::*;
#(
  parameter int DEPTH         = 4,
  parameter int VALUE_BITS    = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [23:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,
  input  logic [1:0]  m_axis_tuser_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          refused_full_o,
  output int          refused_empty_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] value;
    logic [7:0]  prio;
    logic [2:0]  count;
  } response_t;

  logic [15:0] held_value [DEPTH];
  logic [7:0]  held_priority [DEPTH];
  int          held_count;
  response_t   pending_responses [$];
  int          fails;
  int          checked;
  int          n_full;
  int          n_empty;

  // Applies one request to the shadow queue and returns the response it causes.
  function automatic response_t serve_request(input logic act, input logic [15:0] value,
                                              input logic [7:0] prio);
    response_t resp;
    int        best;
    resp = '0;
    resp.status = STATUS_OK;
    if (act == ACTION_INSERT) begin
      if (held_count >= DEPTH) begin
        resp.status = STATUS_FULL;
      end else begin
        held_value[held_count]    = value;
        held_priority[held_count] = prio;
        held_count++;
        resp.value = value;
        resp.prio  = prio;
      end
    end else begin
      if (held_count == 0) begin
        resp.status = STATUS_EMPTY;
      end else begin
        // Strictly greater wins, so the earliest entry keeps a full tie.
        best = 0;
        for (int k = 1; k < held_count; k++) begin
          if (held_priority[k] > held_priority[best] ||
              (held_priority[k] == held_priority[best] && held_value[k] > held_value[best]))
            best = k;
        end
        resp.value = held_value[best];
        resp.prio  = held_priority[best];
        for (int k = best; k + 1 < held_count; k++) begin
          held_value[k]    = held_value[k + 1];
          held_priority[k] = held_priority[k + 1];
        end
        held_count--;
      end
    end
    resp.count = 3'(held_count);
    return resp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    response_t got;
    response_t want;
    if (!rst_ni) begin
      held_count = 0;
      pending_responses.delete();
      fails   = 0;
      checked = 0;
      n_full  = 0;
      n_empty = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        pending_responses.push_back(serve_request(s_axis_tuser_i, s_axis_tdata_i[15:0],
                                                  s_axis_tdata_i[23:16]));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.status = m_axis_tuser_i;
        got.value  = m_axis_tdata_i[15:0];
        got.prio   = m_axis_tdata_i[23:16];
        got.count  = m_axis_tdata_i[26:24];
        checked++;
        if (got.status == STATUS_FULL) n_full++;
        if (got.status == STATUS_EMPTY) n_empty++;
        if (pending_responses.size() == 0) begin
          fails++;
          $display("%0t: unexpected response: expected none, actual status %0d value %h %s",
                   $time, got.status, got.value, "");
          $display("%0t:           actual priority %h count %0d",
                   $time, got.prio, got.count);
        end else begin
          want = pending_responses.pop_front();
          if (got != want) begin
            fails++;
            $display("%0t: mismatch: expected status %0d value %h priority %h count %0d",
                     $time, want.status, want.value, want.prio, want.count);
            $display("%0t:           actual status %0d value %h priority %h count %0d",
                     $time, got.status, got.value, got.prio, got.count);
          end
        end
      end
    end
    fail_count_o    <= fails;
    pending_o       <= pending_responses.size();
    checked_o       <= checked;
    refused_full_o  <= n_full;
    refused_empty_o <= n_empty;
  end

endmodule

// ===== tb/sv/linear_scan_priority_queue_unit_tb.sv =====
`timescale 1ns / 100ps

module linear_scan_priority_queue_unit_tb
  import lspq_pkg::*;
();

  localparam int DEPTH         = 4;
  localparam int VALUE_BITS    = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int RANDOM_ITEMS  = 550;
  localparam int PHASE_ITEMS   = RANDOM_ITEMS / 4;
  localparam int CYCLE_LIMIT   = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = ACTION_INSERT;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  int fail_count;
  int pending;
  int checked;
  int refused_full;
  int refused_empty;
  int idle_pct  = 0;
  int stall_pct = 0;
  int cycles    = 0;
  int n_insert  = 0;
  int n_remove  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  linear_scan_priority_queue_unit #(
    .DEPTH        (DEPTH),
    .VALUE_BITS   (VALUE_BITS),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  linear_scan_priority_queue_unit_checker #(
    .DEPTH        (DEPTH),
    .VALUE_BITS   (VALUE_BITS),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .m_axis_tuser_i (m_axis_tuser_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .refused_full_o (refused_full),
    .refused_empty_o(refused_empty)
  );

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[linear_scan_priority_queue_unit] ERROR");
      $finish;
    end
  end

  // Returns after the request has been accepted; valid stays high for a back-to-back request.
  task automatic send_request(input logic act, input logic [15:0] value,
                              input logic [7:0] prio);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= {prio, value};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (act == ACTION_INSERT) n_insert++;
    else n_remove++;
  endtask

  // Small and near-maximum values are common so that priority ties and full ties show up often.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 3));
      1: return 16'hFFFF - 16'($urandom_range(0, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_priority();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 2));
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_phase(input int sender_idle, input int receiver_stall);
    int sent;
    int n_ins;
    int n_rem;
    sent      = 0;
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        // A burst of inserts followed by a burst of removes drives the queue to both ends.
        n_ins = $urandom_range(0, DEPTH + 2);
        n_rem = $urandom_range(0, DEPTH + 2);
        repeat (n_ins) send_request(ACTION_INSERT, pick_value(), pick_priority());
        repeat (n_rem) send_request(ACTION_REMOVE, pick_value(), pick_priority());
        sent += n_ins + n_rem;
      end else begin
        send_request(1'($urandom), 16'($urandom), 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty and full refusals, priority zero, value and full ties.
    send_request(ACTION_REMOVE, 16'h0000, 8'h00);
    send_request(ACTION_INSERT, 16'h0000, 8'h00);
    send_request(ACTION_REMOVE, 16'hFFFF, 8'hFF);
    send_request(ACTION_INSERT, 16'h1234, 8'h00);
    send_request(ACTION_INSERT, 16'hFFFF, 8'hFF);
    send_request(ACTION_INSERT, 16'h0001, 8'hFF);
    send_request(ACTION_INSERT, 16'hFFFF, 8'hFF);
    send_request(ACTION_INSERT, 16'h0005, 8'h07);
    send_request(ACTION_REMOVE, 16'h0000, 8'h00);
    send_request(ACTION_REMOVE, 16'h0000, 8'h00);
    send_request(ACTION_REMOVE, 16'h0000, 8'h00);
    send_request(ACTION_REMOVE, 16'h0000, 8'h00);
    send_request(ACTION_REMOVE, 16'h0000, 8'h00);
    send_request(ACTION_INSERT, 16'h0002, 8'h00);
    send_request(ACTION_INSERT, 16'h0009, 8'h00);
    send_request(ACTION_INSERT, 16'hA5A5, 8'h80);
    send_request(ACTION_INSERT, 16'h5A5A, 8'h80);
    send_request(ACTION_INSERT, 16'hFFFF, 8'hFF);
    send_request(ACTION_REMOVE, 16'h0000, 8'h00);
    send_request(ACTION_REMOVE, 16'h0000, 8'h00);
    send_request(ACTION_REMOVE, 16'h0000, 8'h00);
    send_request(ACTION_REMOVE, 16'h0000, 8'h00);

    run_phase(0, 0);
    run_phase(69, 0);
    run_phase(0, 69);
    run_phase(6, 6);

    s_axis_tvalid_i <= 1'b0;
    stall_pct = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d requests (%0d inserts, %0d removes) under four idle and stall mixes.",
             n_insert + n_remove, n_insert, n_remove);
    $display("Checked %0d responses, %0d refused as full and %0d refused as empty.",
             checked, refused_full, refused_empty);
    if (fail_count == 0 && pending == 0) begin
      $display("[linear_scan_priority_queue_unit] OK");
    end else begin
      $display("[linear_scan_priority_queue_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== linear_scan_priority_queue_unit.f =====
rtl/lspq_pkg.sv
rtl/lspq_ctrl.sv
rtl/lspq_dp.sv
rtl/linear_scan_priority_queue_unit.sv
tb/sv/linear_scan_priority_queue_unit_checker.sv
tb/sv/linear_scan_priority_queue_unit_tb.sv
